### hdl/tfd_pkg.sv
// ----------------------------------------------------------------------------
// tfd_pkg
// Shared types, codes and constants of the TLV frame deframer with CRC-16.
// ----------------------------------------------------------------------------
package tfd_pkg;

    // frame layout
    localparam int unsigned MAX_FRAME_BYTES_DEF = 8;
    localparam int unsigned MIN_LEN             = 6;
    localparam int unsigned OVERHEAD_BYTES      = 5;
    localparam int unsigned HDR_BYTES           = 3;
    localparam int unsigned MAX_VALUE_BYTES     = 3;

    // crc-16 itu-t
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT   = 3'd3;

    // register reset values
    localparam logic [7:0]  START_BYTE_RST = 8'hFD;
    localparam logic [3:0]  MIN_LEN_RST    = 4'd6;
    localparam logic [3:0]  MAX_LEN_RST    = 4'd8;
    localparam logic [15:0] CRC_INIT_RST   = 16'h0000;

    // result status codes
    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_CRC_ERR = 2'd1,
        ST_LEN_ERR = 2'd2
    } status_t;

    // receive phases
    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_TAG    = 3'd1,
        PH_LEN    = 3'd2,
        PH_VALUE  = 3'd3,
        PH_CRC_HI = 3'd4,
        PH_CRC_LO = 3'd5
    } phase_t;

    // configuration registers as seen by the parser
    typedef struct packed {
        logic [7:0]  start_byte;
        logic [3:0]  min_frame_len;
        logic [3:0]  max_frame_len;
        logic [15:0] crc_init;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] frame_tag;
        logic [7:0] frame_length;
        logic [1:0] value_count;
        logic [7:0] value_first;
        logic [7:0] value_second;
        logic [7:0] value_third;
    } result_t;

endpackage

### hdl/tfd_byte_if.sv
// ----------------------------------------------------------------------------
// tfd_byte_if
// Valid/ready channel carrying one received byte per transfer.
// ----------------------------------------------------------------------------
interface tfd_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface

### hdl/tfd_result_if.sv
// ----------------------------------------------------------------------------
// tfd_result_if
// Valid/ready channel carrying one frame report per transfer.
// ----------------------------------------------------------------------------
interface tfd_result_if;

    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] frame_tag;
    logic [7:0] frame_length;
    logic [1:0] value_count;
    logic [7:0] value_first;
    logic [7:0] value_second;
    logic [7:0] value_third;

    modport source (
        output valid, output status, output frame_tag, output frame_length,
        output value_count, output value_first, output value_second,
        output value_third, input ready
    );
    modport sink (
        input valid, input status, input frame_tag, input frame_length,
        input value_count, input value_first, input value_second,
        input value_third, output ready
    );

endinterface

### hdl/tfd_cfg_regs.sv
// ----------------------------------------------------------------------------
// tfd_cfg_regs
// Configuration register file: start byte, length bounds and crc seed.
// ----------------------------------------------------------------------------
module tfd_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tfd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tfd_pkg::CFG_DATA_W-1:0]       cfg_data,
    output tfd_pkg::cfg_t                        cfg
);

    tfd_pkg::cfg_t cfg_reg;
    tfd_pkg::cfg_t cfg_next;

    // register write decode, unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                tfd_pkg::REG_START_BYTE: cfg_next.start_byte    = cfg_data[7:0];
                tfd_pkg::REG_MIN_LEN:    cfg_next.min_frame_len = cfg_data[3:0];
                tfd_pkg::REG_MAX_LEN:    cfg_next.max_frame_len = cfg_data[3:0];
                tfd_pkg::REG_CRC_INIT:   cfg_next.crc_init      = cfg_data[15:0];
                default:                 cfg_next               = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte    <= tfd_pkg::START_BYTE_RST;
            cfg_reg.min_frame_len <= tfd_pkg::MIN_LEN_RST;
            cfg_reg.max_frame_len <= tfd_pkg::MAX_LEN_RST;
            cfg_reg.crc_init      <= tfd_pkg::CRC_INIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/tfd_crc16.sv
// ----------------------------------------------------------------------------
// tfd_crc16
// One-byte update of CRC-16 ITU-T, msb first, no reflection.
// ----------------------------------------------------------------------------
module tfd_crc16
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);

    logic [15:0] crc_work;

    // eight shift steps of the polynomial divider
    always_comb
    begin
        crc_work = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (crc_work[15])
            begin
                crc_work = {crc_work[14:0], 1'b0} ^ tfd_pkg::CRC_POLY;
            end
            else
            begin
                crc_work = {crc_work[14:0], 1'b0};
            end
        end
        crc_out = crc_work;
    end

endmodule

### hdl/tfd_parser.sv
// ----------------------------------------------------------------------------
// tfd_parser
// Frame state machine: hunts for the start byte, checks length, gathers
// value bytes, runs the crc and builds the frame report.
// ----------------------------------------------------------------------------
module tfd_parser
#(
    parameter int unsigned MAX_FRAME_BYTES = tfd_pkg::MAX_FRAME_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  tfd_pkg::cfg_t     cfg,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    output tfd_pkg::result_t  res
);

    localparam int unsigned VALUE_DEPTH = MAX_FRAME_BYTES - tfd_pkg::OVERHEAD_BYTES;
    localparam logic [7:0]  MAX_LEN     = 8'(MAX_FRAME_BYTES);
    localparam logic [7:0]  MIN_LEN     = 8'(tfd_pkg::MIN_LEN);
    localparam logic [3:0]  HDR_BYTES   = 4'(tfd_pkg::HDR_BYTES);
    localparam logic [3:0]  VALUE_END   = 4'(tfd_pkg::HDR_BYTES + tfd_pkg::MAX_VALUE_BYTES);

    tfd_pkg::phase_t phase_reg, phase_next;
    logic [3:0]      byte_count_reg, byte_count_next;
    logic [7:0]      tag_reg, tag_next;
    logic [7:0]      length_reg, length_next;
    logic [15:0]     crc_reg, crc_next;
    logic [7:0]      crc_hi_reg, crc_hi_next;
    logic [7:0]      value_reg [VALUE_DEPTH];

    logic [15:0]     crc_seed;
    logic [15:0]     crc_upd;
    logic            start_hit;
    logic            len_ok;
    logic [3:0]      count_inc;
    logic            value_done;
    logic [3:0]      slot_diff;
    logic [1:0]      value_slot;
    logic [1:0]      value_cnt;
    logic [7:0]      len_minus2;
    logic [7:0]      val_sel [tfd_pkg::MAX_VALUE_BYTES];

    // byte-wide crc update, seeded from the register at the start byte
    assign crc_seed = (phase_reg == tfd_pkg::PH_HUNT) ? cfg.crc_init : crc_reg;

    tfd_crc16 u_crc
    (
        .crc_in  (crc_seed),
        .data    (rx_byte),
        .crc_out (crc_upd)
    );

    // decode helpers
    assign start_hit  = (rx_byte == cfg.start_byte);
    assign len_ok     = (rx_byte >= {4'd0, cfg.min_frame_len})
                     && (rx_byte <= {4'd0, cfg.max_frame_len})
                     && (rx_byte >= MIN_LEN) && (rx_byte <= MAX_LEN);
    assign count_inc  = byte_count_reg + 4'd1;
    assign len_minus2 = length_reg - 8'd2;
    assign value_done = ({4'd0, count_inc} >= len_minus2) || (count_inc >= VALUE_END);
    assign slot_diff  = byte_count_reg - HDR_BYTES;
    assign value_slot = (slot_diff == 4'd0) ? 2'd0 :
                        (slot_diff > 4'd2)  ? 2'd2 : slot_diff[1:0];
    assign value_cnt  = 2'(length_reg - 8'(tfd_pkg::OVERHEAD_BYTES));

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            unique case (phase_reg)
                tfd_pkg::PH_HUNT:   phase_next = start_hit ? tfd_pkg::PH_TAG : tfd_pkg::PH_HUNT;
                tfd_pkg::PH_TAG:    phase_next = tfd_pkg::PH_LEN;
                tfd_pkg::PH_LEN:    phase_next = len_ok ? tfd_pkg::PH_VALUE : tfd_pkg::PH_HUNT;
                tfd_pkg::PH_VALUE:  phase_next = value_done ? tfd_pkg::PH_CRC_HI
                                                            : tfd_pkg::PH_VALUE;
                tfd_pkg::PH_CRC_HI: phase_next = tfd_pkg::PH_CRC_LO;
                tfd_pkg::PH_CRC_LO: phase_next = tfd_pkg::PH_HUNT;
                default:            phase_next = tfd_pkg::PH_HUNT;
            endcase
        end
    end

    // datapath register updates
    always_comb
    begin
        byte_count_next = byte_count_reg;
        tag_next        = tag_reg;
        length_next     = length_reg;
        crc_next        = crc_reg;
        crc_hi_next     = crc_hi_reg;
        if (step)
        begin
            unique case (phase_reg)
                tfd_pkg::PH_HUNT:
                begin
                    if (start_hit)
                    begin
                        crc_next        = crc_upd;
                        byte_count_next = 4'd1;
                    end
                end
                tfd_pkg::PH_TAG:
                begin
                    tag_next        = rx_byte;
                    crc_next        = crc_upd;
                    byte_count_next = 4'd2;
                end
                tfd_pkg::PH_LEN:
                begin
                    length_next = rx_byte;
                    if (len_ok)
                    begin
                        crc_next        = crc_upd;
                        byte_count_next = HDR_BYTES;
                    end
                    else
                    begin
                        byte_count_next = 4'd0;
                    end
                end
                tfd_pkg::PH_VALUE:
                begin
                    crc_next        = crc_upd;
                    byte_count_next = count_inc;
                end
                tfd_pkg::PH_CRC_HI:
                begin
                    crc_hi_next     = rx_byte;
                    byte_count_next = count_inc;
                end
                tfd_pkg::PH_CRC_LO:
                begin
                    byte_count_next = 4'd0;
                end
                default:
                begin
                    byte_count_next = 4'd0;
                end
            endcase
        end
    end

    // value fields beyond the count read as zero
    for (genvar k = 0; k < tfd_pkg::MAX_VALUE_BYTES; k++)
    begin : g_val_sel
        if (k < VALUE_DEPTH)
        begin : g_stored
            assign val_sel[k] = (value_cnt > 2'(k)) ? value_reg[k] : 8'd0;
        end
        else
        begin : g_absent
            assign val_sel[k] = 8'd0;
        end
    end

    // report outputs
    always_comb
    begin
        res_valid        = 1'b0;
        res.status       = tfd_pkg::ST_GOOD;
        res.frame_tag    = tag_reg;
        res.frame_length = length_reg;
        res.value_count  = 2'd0;
        res.value_first  = 8'd0;
        res.value_second = 8'd0;
        res.value_third  = 8'd0;
        unique case (phase_reg)
            tfd_pkg::PH_LEN:
            begin
                res_valid        = step && !len_ok;
                res.status       = tfd_pkg::ST_LEN_ERR;
                res.frame_length = rx_byte;
            end
            tfd_pkg::PH_CRC_LO:
            begin
                res_valid        = step;
                res.status       = ({crc_hi_reg, rx_byte} == crc_reg) ? tfd_pkg::ST_GOOD
                                                                      : tfd_pkg::ST_CRC_ERR;
                res.value_count  = value_cnt;
                res.value_first  = val_sel[0];
                res.value_second = val_sel[1];
                res.value_third  = val_sel[2];
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // control and header registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= tfd_pkg::PH_HUNT;
            byte_count_reg <= 4'd0;
            tag_reg        <= 8'd0;
            length_reg     <= 8'd0;
            crc_reg        <= 16'd0;
            crc_hi_reg     <= 8'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            tag_reg        <= tag_next;
            length_reg     <= length_next;
            crc_reg        <= crc_next;
            crc_hi_reg     <= crc_hi_next;
        end
    end

    // value byte store
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < VALUE_DEPTH; k++)
        begin
            if (step && (phase_reg == tfd_pkg::PH_VALUE) && (value_slot == 2'(k)))
            begin
                value_reg[k] <= rx_byte;
            end
        end
    end

endmodule

### hdl/tlv_frame_deframer_crc16.sv
// ----------------------------------------------------------------------------
// tlv_frame_deframer_crc16
// TLV frame deframer with CRC-16 ITU-T check.
//
// Received bytes come in on rx, one per transfer. The block hunts for the
// configured start byte, then takes tag, total length, one to three value
// bytes and a big-endian CRC. For every frame it sends one report on res:
// good frame, crc mismatch, or length out of range (sent right after the
// length byte, hunting resumes with the next byte).
// Throughput: one byte per cycle while res is not stalled. A byte goes into
// an input register and is parsed from there; its report lands in the
// output register, from which res offers it. The per-byte crc update sets
// the critical path.
// When res is stalled with a report pending, the input register still
// takes one byte; further bytes wait until res takes the report.
// Reset returns the block to hunting and loads the register defaults
// (start byte 0xfd, lengths 6 to 8, crc seed zero). Configuration is written
// through cfg_we / cfg_index / cfg_data; the user must write it only while
// no frame is in progress, and the block does not enforce this.
// ----------------------------------------------------------------------------
module tlv_frame_deframer_crc16
#(
    parameter int unsigned MAX_FRAME_BYTES = tfd_pkg::MAX_FRAME_BYTES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tfd_pkg::CFG_DATA_W-1:0] cfg_data,
    tfd_byte_if.sink                       rx,
    tfd_result_if.source                   res
);

    tfd_pkg::cfg_t    cfg;
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             advance;
    logic             p_valid;
    tfd_pkg::result_t p_res;
    logic             out_valid_reg;
    tfd_pkg::result_t out_reg;

    tfd_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // the held byte moves on once the result slot is free this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || res.ready);
    assign rx.ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    tfd_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .res_valid (p_valid),
        .res       (p_res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && p_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && p_valid)
        begin
            out_reg <= p_res;
        end
    end

    // result channel
    assign res.valid        = out_valid_reg;
    assign res.status       = out_reg.status;
    assign res.frame_tag    = out_reg.frame_tag;
    assign res.frame_length = out_reg.frame_length;
    assign res.value_count  = out_reg.value_count;
    assign res.value_first  = out_reg.value_first;
    assign res.value_second = out_reg.value_second;
    assign res.value_third  = out_reg.value_third;

endmodule
